### hw/rtl/cfp_pkg.sv
// cfp_pkg: shared types, sync constants and the byte-wide CRC-16 step
// for the sync frame parser. No dependencies.
package cfp_pkg;

    localparam logic [7:0]  SYNC_B0  = 8'hD5;
    localparam logic [7:0]  SYNC_B1  = 8'hD5;
    localparam logic [7:0]  SYNC_B2  = 8'hAA;
    localparam logic [7:0]  SYNC_B3  = 8'h96;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

    // One result transaction.
    typedef struct packed {
        logic        is_frame_end;
        logic [7:0]  payload_byte;
        logic [15:0] frame_command;
        logic [15:0] frame_length;
        logic        crc_match;
    } t_result;

    // CRC-16, MSB first, one byte folded in.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (r[15]) begin
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

### hw/rtl/cfp_apb_regs.sv
// cfp_apb_regs: APB register file holding the maximum payload length.
// Depends on cfp_pkg.
module cfp_apb_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] o_max_len
);

    logic [15:0] r_max_len;
    logic        w_sel_max;

    assign w_sel_max = (paddr[2] == 1'b0);
    assign pready    = 1'b1;
    assign prdata    = w_sel_max ? {16'h0000, r_max_len} : 32'h0000_0000;
    assign o_max_len = r_max_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= cfp_pkg::MAX_LEN_RESET;
        end else if (psel && penable && pwrite && pready && w_sel_max) begin
            r_max_len <= pwdata[15:0];
        end
    end

endmodule

### hw/rtl/cfp_parser.sv
// cfp_parser: sync hunt, header capture, running CRC and result build.
// Depends on cfp_pkg.
module cfp_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_rx_byte,
    input  logic [15:0]      i_max_len,
    output logic             o_res_valid,
    output cfp_pkg::t_result o_res
);

    typedef enum logic [3:0] {
        PH_SYNC0  = 4'd0,
        PH_SYNC1  = 4'd1,
        PH_SYNC2  = 4'd2,
        PH_SYNC3  = 4'd3,
        PH_CMD_LO = 4'd4,
        PH_CMD_HI = 4'd5,
        PH_LEN_LO = 4'd6,
        PH_LEN_HI = 4'd7,
        PH_DATA   = 4'd8,
        PH_CRC_LO = 4'd9,
        PH_CRC_HI = 4'd10
    } t_phase;

    t_phase      r_phase,   n_phase;
    logic [15:0] r_cmd,     n_cmd;
    logic [15:0] r_len,     n_len;
    logic [15:0] r_count,   n_count;
    logic [15:0] r_crc,     n_crc;
    logic [7:0]  r_crc_lo,  n_crc_lo;
    logic [15:0] w_crc_step;
    logic [15:0] w_len_full;
    logic [15:0] w_count_inc;

    assign w_crc_step  = cfp_pkg::crc16_byte(r_crc, i_rx_byte);
    assign w_len_full  = {i_rx_byte, r_len[7:0]};
    assign w_count_inc = r_count + 16'd1;

    always_comb begin
        n_phase     = r_phase;
        n_cmd       = r_cmd;
        n_len       = r_len;
        n_count     = r_count;
        n_crc       = r_crc;
        n_crc_lo    = r_crc_lo;
        o_res_valid = 1'b0;
        o_res       = '0;
        case (r_phase)
            PH_SYNC1: begin
                n_phase = (i_rx_byte == cfp_pkg::SYNC_B1) ? PH_SYNC2 : PH_SYNC0;
            end
            PH_SYNC2: begin
                n_phase = (i_rx_byte == cfp_pkg::SYNC_B2) ? PH_SYNC3 : PH_SYNC0;
            end
            PH_SYNC3: begin
                if (i_rx_byte == cfp_pkg::SYNC_B3) begin
                    n_cmd    = '0;
                    n_len    = '0;
                    n_count  = '0;
                    n_crc    = '0;
                    n_crc_lo = '0;
                    n_phase  = PH_CMD_LO;
                end else begin
                    n_phase = PH_SYNC0;
                end
            end
            PH_CMD_LO: begin
                n_crc   = w_crc_step;
                n_cmd   = {8'h00, i_rx_byte};
                n_phase = PH_CMD_HI;
            end
            PH_CMD_HI: begin
                n_crc   = w_crc_step;
                n_cmd   = {i_rx_byte, r_cmd[7:0]};
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_crc   = w_crc_step;
                n_len   = {8'h00, i_rx_byte};
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_crc = w_crc_step;
                n_len = w_len_full;
                if (w_len_full > i_max_len) begin
                    n_phase = PH_SYNC0;
                end else if (w_len_full == 16'd0) begin
                    n_phase = PH_CRC_LO;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                n_crc   = w_crc_step;
                n_count = w_count_inc;
                if (w_count_inc == r_len) begin
                    n_phase = PH_CRC_LO;
                end
                o_res_valid        = i_accept;
                o_res.payload_byte = i_rx_byte;
            end
            PH_CRC_LO: begin
                n_crc_lo = i_rx_byte;
                n_phase  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                n_phase             = PH_SYNC0;
                o_res_valid         = i_accept;
                o_res.is_frame_end  = 1'b1;
                o_res.frame_command = r_cmd;
                o_res.frame_length  = r_len;
                o_res.crc_match     = ({i_rx_byte, r_crc_lo} == r_crc);
            end
            default: begin
                // first sync byte; unused codes behave the same
                n_phase = (i_rx_byte == cfp_pkg::SYNC_B0) ? PH_SYNC1 : PH_SYNC0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SYNC0;
            r_cmd    <= '0;
            r_len    <= '0;
            r_count  <= '0;
            r_crc    <= '0;
            r_crc_lo <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_cmd    <= n_cmd;
            r_len    <= n_len;
            r_count  <= n_count;
            r_crc    <= n_crc;
            r_crc_lo <= n_crc_lo;
        end
    end

    a_res_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (i_accept && (r_phase == PH_DATA || r_phase == PH_CRC_HI)))
        else $error("result without an accepted byte in a data or crc phase");

    a_long_frame_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_phase == PH_LEN_HI && w_len_full > i_max_len) |=> r_phase == PH_SYNC0)
        else $error("oversize frame not abandoned");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_count < r_len))
        else $error("payload count ran past the frame length");

endmodule

### hw/rtl/cfp_out_reg.sv
// cfp_out_reg: result output register; decouples the parser from a
// stalled consumer. Depends on cfp_pkg.
module cfp_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  cfp_pkg::t_result i_res,
    output logic             o_can_load,
    output logic             o_valid,
    input  logic             i_ready,
    output cfp_pkg::t_result o_res
);

    logic             r_valid;
    cfp_pkg::t_result r_res;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_can_load)
        else $error("pending result overwritten");

endmodule

### hw/rtl/crc16_sync_frame_parser.sv
// crc16_sync_frame_parser: top level; APB register, parser core and
// output register. Depends on cfp_pkg, cfp_apb_regs, cfp_parser, cfp_out_reg.
//
// Byte-stream frame parser. Each input transaction carries one received byte.
// The block hunts for the sync word D5 D5 AA 96 (a wrong byte at any sync
// step restarts the hunt and is not itself rechecked as a first sync byte),
// then reads a little-endian 16-bit command, a little-endian 16-bit length,
// the payload and a little-endian CRC-16 (poly 0x1021, init 0, MSB first,
// no final xor) covering command, length and payload. Every payload byte
// leaves as its own output transaction with o_is_frame_end low as soon as it
// arrives, so a consumer must drop the frame's bytes if the final check
// fails. The last CRC byte produces one frame-end transaction carrying the
// command, the length and o_crc_match. A length above max_payload_len
// (APB offset 0x0, bits 15:0, reset 1024) drops the frame with no output.
// Throughput is one byte per clock when not stalled: the phase update and the
// single-byte CRC step sit between the parser state registers and the output
// register. A result is output in the cycle after its byte is accepted; the
// input is held off only while the output register is full and the consumer
// is not taking it. Write the register only while the stream is idle.
module crc16_sync_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_is_frame_end,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_frame_command,
    output logic [15:0] o_frame_length,
    output logic        o_crc_match,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic             w_accept;
    logic             w_can_load;
    logic             w_res_valid;
    logic [15:0]      w_max_len;
    cfp_pkg::t_result w_res;
    cfp_pkg::t_result w_out_res;

    // A byte is taken whenever the output register has room (or is
    // draining this cycle); bytes that make no result are taken the same way.
    assign o_in_ready = w_can_load;
    assign w_accept   = i_in_valid && o_in_ready;

    cfp_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_max_len (w_max_len)
    );

    cfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_rx_byte   (i_rx_byte),
        .i_max_len   (w_max_len),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    cfp_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_res_valid),
        .i_res      (w_res),
        .o_can_load (w_can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_res      (w_out_res)
    );

    assign o_is_frame_end  = w_out_res.is_frame_end;
    assign o_payload_byte  = w_out_res.payload_byte;
    assign o_frame_command = w_out_res.frame_command;
    assign o_frame_length  = w_out_res.frame_length;
    assign o_crc_match     = w_out_res.crc_match;

endmodule
